/* rtl/uctd_pkg.sv */
package uctd_pkg;

  localparam int DECK_SIZE = 52;
  localparam int CARD_W    = 6;
  localparam int SEAT_W    = 2;
  localparam int SEAT_FIELDS = 4;
  localparam int SEED_W    = 32;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_PLAY  = 2'd1,
    CMD_DEAL  = 2'd2,
    CMD_DETER = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [SEAT_W-1:0]    observer_seat;
    logic [CARD_W-1:0]    card;
    logic [DECK_SIZE-1:0] own_hand;
    logic [DECK_SIZE-1:0] table_cards;
    logic [2:0]           player_count;
    logic [CARD_W-1:0]    hand_size_0;
    logic [CARD_W-1:0]    hand_size_1;
    logic [CARD_W-1:0]    hand_size_2;
    logic [CARD_W-1:0]    hand_size_3;
  } item_t;

  typedef struct packed {
    logic [SEAT_W-1:0]    seat;
    logic [DECK_SIZE-1:0] hand;
    logic [DECK_SIZE-1:0] unseen_set;
    logic [CARD_W-1:0]    unseen_total;
    logic                 last;
  } result_t;

endpackage

/* rtl/unseen_card_tracker_and_dealer_unit.sv */
// Unseen-card tracker and random dealer.
// Input channel (item_valid/item_stall) carries one command; a transfer
// happens when valid is high and stall low. Stall stays high while a command
// is being worked on. Output channel (result_valid/result_stall) carries
// status or hand results from an output register; 'last' marks the final one.
// cfg_valid/cfg_ready writes the seed register (always ready).
// Init and deal run a bit scan over the deck that counts the unseen set.
// Determinize: a bit scan writes the unseen cards into the card list, then
// the demand of the dealt seats is summed; each draw steps the generator,
// takes the remainder in the remainder unit and swaps two list entries (read
// i, read j, write i, write j); then the seats are dealt in order, card by
// card from the list. One item at a time.
// Reset clears the unseen set, count and observer seat, and sets generator
// and seed to one. The card list needs no clearing. A stalled receiver holds
// the result in the output register and the sequencer waits for it.
module unseen_card_tracker_and_dealer_unit #(
  parameter int MAX_PLAYERS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  uctd_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output uctd_pkg::result_t           result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [uctd_pkg::SEED_W-1:0] cfg_data
);
  import uctd_pkg::*;

  localparam int SEAT_LIMIT = (MAX_PLAYERS < SEAT_FIELDS) ? MAX_PLAYERS : SEAT_FIELDS;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SCAN  = 13'b0000000000010,
    S_SUM   = 13'b0000000000100,
    S_RNG   = 13'b0000000001000,
    S_DIV   = 13'b0000000010000,
    S_RDI   = 13'b0000000100000,
    S_RDJ   = 13'b0000001000000,
    S_WRI   = 13'b0000010000000,
    S_WRJ   = 13'b0000100000000,
    S_SEAT  = 13'b0001000000000,
    S_DRD   = 13'b0010000000000,
    S_DOR   = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_t;

  state_t state;

  logic [DECK_SIZE-1:0] unseen_cards;
  logic [CARD_W-1:0]    unseen_num;
  logic [SEAT_W-1:0]    observer_index;
  logic [SEED_W-1:0]    prng_state;
  logic [SEED_W-1:0]    seed_start;

  logic                 det;
  logic [DECK_SIZE-1:0] own;
  logic [CARD_W-1:0]    sizes [SEAT_FIELDS];
  logic [2:0]           seats;
  logic [CARD_W-1:0]    idx;
  logic [CARD_W-1:0]    cnt;
  logic [CARD_W-1:0]    list_len;
  logic [CARD_W-1:0]    needed;
  logic [CARD_W-1:0]    i_pos;
  logic [CARD_W-1:0]    j_pos;
  logic [CARD_W-1:0]    ci;
  logic [CARD_W-1:0]    deal_pos;
  logic [CARD_W-1:0]    dealt;
  logic [SEAT_W-1:0]    p;
  logic [DECK_SIZE-1:0] hand;

  // card list memory
  logic [CARD_W-1:0] card_list [DECK_SIZE];
  logic              mem_we;
  logic [CARD_W-1:0] mem_waddr, mem_wdata, mem_raddr, mem_q;

  logic              div_start, div_done;
  logic [CARD_W-1:0] div_rem;
  logic [SEED_W-1:0] x1, x2, x3;
  logic [7:0]        need_sum;
  logic [2:0]        seats_in;
  logic              scan_bit;
  logic              emit_ok;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign emit_ok    = !result_valid || !result_stall;
  assign scan_bit   = unseen_cards[idx];

  // xorshift32 step
  assign x1 = prng_state ^ (prng_state << 13);
  assign x2 = x1 ^ (x1 >> 17);
  assign x3 = x2 ^ (x2 << 5);

  // seat clamp and demand of the dealt seats
  always_comb begin
    seats_in = (item.player_count > 3'(SEAT_LIMIT)) ? 3'(SEAT_LIMIT) : item.player_count;
    need_sum = '0;
    for (int k = 0; k < SEAT_FIELDS; k++) begin
      if ((3'(k) < seats) && (SEAT_W'(k) != observer_index)) begin
        need_sum = need_sum + 8'(sizes[k]);
      end
    end
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = idx;
    mem_raddr = i_pos;
    div_start = 1'b0;
    unique case (state)
      S_SCAN:  mem_we = det && scan_bit;
      S_RDJ:   mem_raddr = j_pos;
      S_WRI:   begin
        mem_we = 1'b1; mem_waddr = i_pos; mem_wdata = mem_q;
      end
      S_WRJ:   begin
        mem_we = 1'b1; mem_waddr = j_pos; mem_wdata = ci;
      end
      S_DRD:   mem_raddr = deal_pos;
      S_RNG:   div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) card_list[mem_waddr] <= mem_wdata;
    mem_q <= card_list[mem_raddr];
  end

  uctd_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (x3),
    .divisor   (CARD_W'(list_len - i_pos)),
    .done      (div_done),
    .remainder (div_rem)
  );

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_start <= 32'd1;
    end else if (cfg_valid) begin
      seed_start <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      unseen_cards   <= '0;
      unseen_num     <= '0;
      observer_index <= '0;
      prng_state     <= 32'd1;
    end else begin
      // the emit state reloads the output register itself
      if (result_valid && !result_stall && (state != S_EMIT)) result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            own      <= item.own_hand;
            sizes[0] <= item.hand_size_0;
            sizes[1] <= item.hand_size_1;
            sizes[2] <= item.hand_size_2;
            sizes[3] <= item.hand_size_3;
            seats    <= seats_in;
            idx      <= '0;
            cnt      <= '0;
            det      <= 1'b0;
            unique case (cmd_t'(item.cmd))
              CMD_INIT: begin
                observer_index <= item.observer_seat;
                unseen_cards   <= ~(item.own_hand | item.table_cards);
                prng_state     <= seed_start;
                state          <= S_SCAN;
              end
              CMD_PLAY: begin
                if ((item.card < CARD_W'(DECK_SIZE)) && unseen_cards[item.card]) begin
                  unseen_cards[item.card] <= 1'b0;
                  if (unseen_num != '0) unseen_num <= unseen_num - 1'b1;
                end
                state <= S_EMIT;
              end
              CMD_DEAL: begin
                unseen_cards <= unseen_cards & ~item.own_hand;
                state        <= S_SCAN;
              end
              CMD_DETER: begin
                if (seats_in == '0) begin
                  state <= S_EMIT;
                end else begin
                  det   <= 1'b1;
                  state <= S_SCAN;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // one card bit a cycle: count, and in determinize mode list the unseen cards
        S_SCAN: begin
          cnt <= cnt + CARD_W'(scan_bit);
          idx <= idx + 1'b1;
          if (idx == CARD_W'(DECK_SIZE - 1)) begin
            if (det) begin
              list_len <= cnt + CARD_W'(scan_bit);
              state    <= S_SUM;
            end else begin
              unseen_num <= cnt + CARD_W'(scan_bit);
              state      <= S_EMIT;
            end
          end
        end
        S_SUM: begin
          needed   <= (need_sum > 8'(list_len)) ? list_len : CARD_W'(need_sum);
          i_pos    <= '0;
          deal_pos <= '0;
          p        <= '0;
          state    <= S_RNG;
        end
        // draw loop
        S_RNG: begin
          if (i_pos == needed) begin
            state <= S_SEAT;
          end else begin
            prng_state <= x3;
            state      <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            j_pos <= i_pos + div_rem;
            state <= S_RDI;
          end
        end
        S_RDI: state <= S_RDJ;
        S_RDJ: begin
          ci    <= mem_q;
          state <= S_WRI;
        end
        S_WRI: state <= S_WRJ;
        S_WRJ: begin
          i_pos <= i_pos + 1'b1;
          state <= S_RNG;
        end
        // deal in seat order
        S_SEAT: begin
          dealt <= '0;
          if (p == observer_index) begin
            hand  <= own;
            state <= S_EMIT;
          end else begin
            hand  <= '0;
            state <= S_DRD;
          end
        end
        S_DRD: begin
          if ((dealt == sizes[p]) || (deal_pos == needed)) begin
            state <= S_EMIT;
          end else begin
            state <= S_DOR;
          end
        end
        S_DOR: begin
          hand[mem_q] <= 1'b1;
          deal_pos    <= deal_pos + 1'b1;
          dealt       <= dealt + 1'b1;
          state       <= S_DRD;
        end
        S_EMIT: begin
          if (emit_ok) begin
            result_valid        <= 1'b1;
            result.seat         <= det ? p : '0;
            result.hand         <= det ? hand : '0;
            result.unseen_set   <= unseen_cards;
            result.unseen_total <= unseen_num;
            if (!det || (3'(p) + 3'd1 == seats)) begin
              result.last <= 1'b1;
              state       <= S_IDLE;
            end else begin
              result.last <= 1'b0;
              p           <= p + 1'b1;
              state       <= S_SEAT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/uctd_mod.sv */
// Restoring remainder unit: one dividend bit per cycle.
module uctd_mod (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [uctd_pkg::SEED_W-1:0]  dividend,
  input  logic [uctd_pkg::CARD_W-1:0]  divisor,
  output logic                         done,
  output logic [uctd_pkg::CARD_W-1:0]  remainder
);
  import uctd_pkg::*;

  logic              busy;
  logic [4:0]        cnt;
  logic [SEED_W-1:0] sh;
  logic [CARD_W-1:0] dvs;
  logic [CARD_W:0]   trial;

  assign trial = {remainder, sh[SEED_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh        <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      sh <= {sh[SEED_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        remainder <= CARD_W'(trial - {1'b0, dvs});
      end else begin
        remainder <= trial[CARD_W-1:0];
      end
    end
  end

endmodule
